// File: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding window median filter
// Pixel and window types, window geometry, line store banking and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int PIX_W = 8;

  // Window geometry: 5x5 centred window, or 3x3 window ending at the pixel.
  localparam int MAX_WINDOW = 5;
  localparam int WIN_REACH  = MAX_WINDOW / 2;
  localparam int SMALL_SPAN = 3;
  localparam int WIN_N      = MAX_WINDOW * MAX_WINDOW;
  localparam int SMALL_N    = SMALL_SPAN * SMALL_SPAN;
  localparam int WIN_MID    = WIN_N / 2;
  // In 3x3 mode the window is padded with equal numbers of minimum and
  // maximum values, which leaves the median of the nine samples in place.
  localparam int PAD_SPLIT  = SMALL_N + (WIN_N - SMALL_N) / 2;

  // Median sorter: odd-even transposition over WIN_N passes.
  localparam int SORT_STAGE_PASSES = 5;
  localparam int SORT_STAGES       = WIN_N / SORT_STAGE_PASSES;

  // Line store: four lines used as a ring, each split into eight column banks.
  localparam int SLOT_BITS = 2;
  localparam int BANK_BITS = 3;
  localparam int BANKS     = 1 << BANK_BITS;

  localparam logic [2:0] ROWS_SAT = 3'd4;

  // Configuration registers.
  localparam int LINE_WIDTH_W = 11;
  localparam int CFG_INDEX_W  = 1;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;
  localparam logic [CFG_INDEX_W-1:0]  CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0]  CFG_WINDOW_MODE  = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  localparam pix_t PAD_LOW  = 8'h00;
  localparam pix_t PAD_HIGH = 8'hFF;

  // Which line a window row is taken from.
  typedef enum logic [1:0] {
    ROW_CUR = 2'd0,
    ROW_M1  = 2'd1,
    ROW_M2  = 2'd2
  } row_src_t;

endpackage

// File: hw/rtl/smf_line_bank.sv
// ----------------------------------------------------------------------------
// smf_line_bank: one column bank of the line store
// Single write port and two registered read ports, one for each of the two
// earlier lines that a window needs.
// ----------------------------------------------------------------------------
module smf_line_bank #(
  parameter int ADDR_W = 9
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  smf_pkg::pix_t       wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output smf_pkg::pix_t       rd_data_a,
  output smf_pkg::pix_t       rd_data_b
);

  smf_pkg::pix_t mem [1 << ADDR_W];
  smf_pkg::pix_t rd_data_a_r;
  smf_pkg::pix_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// File: hw/rtl/smf_sort_stage.sv
// ----------------------------------------------------------------------------
// smf_sort_stage: one registered slice of the median sorting network
// Applies a run of odd-even transposition passes to the window and holds the
// result, with a valid bit and a row end tag that travel alongside.
// ----------------------------------------------------------------------------
module smf_sort_stage #(
  parameter int FIRST_PASS = 0,
  parameter int NUM_PASSES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                in_valid,
  input  logic                in_tag,
  input  smf_pkg::win_t       in_data,
  output logic                out_valid,
  output logic                out_tag,
  output smf_pkg::win_t       out_data
);

  smf_pkg::win_t sorted;
  logic          valid_r;
  logic          tag_r;
  smf_pkg::win_t data_r;

  always_comb begin
    smf_pkg::pix_t tmp;
    tmp    = '0;
    sorted = in_data;
    for (int p = 0; p < NUM_PASSES; p++) begin
      // Pairs of one pass are disjoint, so walking them in order is exact.
      for (int i = 0; i + 1 < smf_pkg::WIN_N; i++) begin
        if ((((FIRST_PASS + p + i) & 1) == 0) && (sorted[i] > sorted[i+1])) begin
          tmp         = sorted[i];
          sorted[i]   = sorted[i+1];
          sorted[i+1] = tmp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_r  <= in_tag;
      data_r <= sorted;
    end
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/sliding_window_median_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_core: 3x3 / 5x5 streaming median filter
// An accepted pixel passes the line store read into the input register,
// then five sorter slices. Throughput: one word per clock when out_stall
// does not hold the sorter chain. Reset (rst_n, synchronous) empties the
// pipeline and clears position, row count and ring slot; line store
// undefined.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_core #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Pixel input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_pixel,
  input  logic                                   in_frame_start,
  // Result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [7:0]                             out_median_value,
  output logic                                   out_row_end,
  // Configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [smf_pkg::LINE_WIDTH_W-1:0]       cfg_data
);

  localparam int ColW  = $clog2(MAX_LINE);
  localparam int HiW   = ColW - smf_pkg::BANK_BITS;
  localparam int AddrW = smf_pkg::SLOT_BITS + HiW;
  localparam int CmpW  = (ColW + 1 > smf_pkg::LINE_WIDTH_W) ? ColW + 1
                                                            : smf_pkg::LINE_WIDTH_W;
  localparam int MaxW  = smf_pkg::MAX_WINDOW;
  localparam int Banks = smf_pkg::BANKS;
  localparam int BankB = smf_pkg::BANK_BITS;
  localparam int Stgs  = smf_pkg::SORT_STAGES;

  // Configuration registers
  logic [smf_pkg::LINE_WIDTH_W-1:0] line_width_r;
  logic                             window_mode_r;

  // Position state
  logic [ColW-1:0]               col_r, col_nxt;
  logic [2:0]                    rows_r, rows_nxt;
  logic [smf_pkg::SLOT_BITS-1:0] slot_r, slot_nxt;
  smf_pkg::pix_t                 last1_r, last2_r;

  // Front end
  logic [CmpW-1:0]               lw_ext, wm1_full;
  logic [ColW-1:0]               wm1;
  logic [ColW-1:0]               c_eff;
  logic [2:0]                    rs_eff;
  logic                          row_end;
  logic [ColW-1:0]               tc [MaxW];
  logic [HiW-1:0]                bank_hi [Banks];
  smf_pkg::pix_t                 cur_far, cur_near;
  smf_pkg::row_src_t             ty_m2, ty_m1;
  logic [smf_pkg::SLOT_BITS-1:0] slot_m1, slot_m2;
  logic                          s1_load;
  logic                          accept;

  // First stage register and line store read data
  logic                          s1_v_r;
  smf_pkg::pix_t                 s1_cur_far_r, s1_cur_near_r, s1_pixel_r;
  logic [BankB-1:0]              s1_bank_r [MaxW];
  smf_pkg::row_src_t             s1_ty_m2_r, s1_ty_m1_r;
  logic                          s1_mode_r;
  logic                          s1_row_end_r;
  smf_pkg::pix_t                 rd_m1 [Banks];
  smf_pkg::pix_t                 rd_m2 [Banks];

  // Window assembly and sorter chain
  smf_pkg::pix_t                 cur_col [MaxW];
  smf_pkg::row_src_t             row_ty [MaxW];
  smf_pkg::pix_t                 samp [MaxW][MaxW];
  smf_pkg::win_t                 win0;
  smf_pkg::win_t                 sd [Stgs+1];
  logic                          sv [Stgs+1];
  logic                          stag [Stgs+1];
  logic                          sload [Stgs];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= smf_pkg::LINE_WIDTH_RESET;
      window_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smf_pkg::CFG_LINE_WIDTH:  line_width_r  <= cfg_data;
        smf_pkg::CFG_WINDOW_MODE: window_mode_r <= cfg_data[0];
      endcase
    end
  end

  // Last usable column: a width of zero acts as one, and widths above the
  // line store act as its full size.
  always_comb begin
    lw_ext = CmpW'(line_width_r);
    if (lw_ext == '0) begin
      wm1_full = '0;
    end else if (lw_ext > CmpW'(MAX_LINE)) begin
      wm1_full = CmpW'(MAX_LINE - 1);
    end else begin
      wm1_full = lw_ext - CmpW'(1);
    end
    wm1 = wm1_full[ColW-1:0];
  end

  // --------------------------------------------------------------------------
  // Position tracking and line store addressing
  // --------------------------------------------------------------------------
  always_comb begin
    c_eff   = in_frame_start ? '0 : col_r;
    rs_eff  = in_frame_start ? '0 : rows_r;
    row_end = (c_eff >= wm1);

    col_nxt  = row_end ? '0 : c_eff + ColW'(1);
    slot_nxt = row_end ? slot_r + smf_pkg::SLOT_BITS'(1) : slot_r;
    if (row_end && (rs_eff < smf_pkg::ROWS_SAT)) begin
      rows_nxt = rs_eff + 3'd1;
    end else begin
      rows_nxt = rs_eff;
    end

    slot_m1 = slot_r - smf_pkg::SLOT_BITS'(1);
    slot_m2 = slot_r - smf_pkg::SLOT_BITS'(2);

    // Rows above the frame fall back to the oldest row of this frame.
    if (rs_eff >= 3'd2) begin
      ty_m2 = smf_pkg::ROW_M2;
    end else if (rs_eff == 3'd1) begin
      ty_m2 = smf_pkg::ROW_M1;
    end else begin
      ty_m2 = smf_pkg::ROW_CUR;
    end
    ty_m1 = (rs_eff != 3'd0) ? smf_pkg::ROW_M1 : smf_pkg::ROW_CUR;

    // Current row: columns left of zero take column zero, and columns not yet
    // arrived take the current pixel.
    cur_near = (c_eff != '0) ? last1_r : in_pixel;
    cur_far  = (c_eff >= ColW'(2)) ? last2_r : cur_near;
  end

  // Earlier rows: window columns clamped to the image.
  always_comb begin
    logic [ColW:0] t;
    for (int k = 0; k < MaxW; k++) begin
      t = (ColW+1)'(c_eff) + (ColW+1)'(k);
      if (t < (ColW+1)'(smf_pkg::WIN_REACH)) begin
        t = '0;
      end else begin
        t = t - (ColW+1)'(smf_pkg::WIN_REACH);
      end
      if (t > {1'b0, wm1}) begin
        t = {1'b0, wm1};
      end
      tc[k] = t[ColW-1:0];
    end
  end

  // The clamped columns are consecutive, so each bank serves at most one.
  always_comb begin
    for (int b = 0; b < Banks; b++) begin
      bank_hi[b] = '0;
      for (int k = 0; k < MaxW; k++) begin
        if (tc[k][BankB-1:0] == BankB'(b)) begin
          bank_hi[b] = tc[k][ColW-1:BankB];
        end
      end
    end
  end

  assign s1_load  = !s1_v_r || sload[0];
  assign accept   = in_valid && s1_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= '0;
      slot_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        rows_r <= rows_nxt;
        slot_r <= slot_nxt;
      end
      if (s1_load) begin
        s1_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r       <= in_pixel;
      last2_r       <= last1_r;
      s1_cur_far_r  <= cur_far;
      s1_cur_near_r <= cur_near;
      s1_pixel_r    <= in_pixel;
      s1_ty_m2_r    <= ty_m2;
      s1_ty_m1_r    <= ty_m1;
      s1_mode_r     <= window_mode_r;
      s1_row_end_r  <= row_end;
      for (int k = 0; k < MaxW; k++) begin
        s1_bank_r[k] <= tc[k][BankB-1:0];
      end
    end
  end

  for (genvar b = 0; b < Banks; b++) begin : g_bank
    smf_line_bank #(
      .ADDR_W (AddrW)
    ) u_bank (
      .clk       (clk),
      .wr_en     (accept && (c_eff[BankB-1:0] == BankB'(b))),
      .wr_addr   ({slot_r, c_eff[ColW-1:BankB]}),
      .wr_data   (in_pixel),
      .rd_en     (accept),
      .rd_addr_a ({slot_m1, bank_hi[b]}),
      .rd_addr_b ({slot_m2, bank_hi[b]}),
      .rd_data_a (rd_m1[b]),
      .rd_data_b (rd_m2[b])
    );
  end

  // --------------------------------------------------------------------------
  // Window assembly
  // --------------------------------------------------------------------------
  always_comb begin
    cur_col[0] = s1_cur_far_r;
    cur_col[1] = s1_cur_near_r;
    for (int j = 2; j < MaxW; j++) begin
      cur_col[j] = s1_pixel_r;
    end
    row_ty[0] = s1_ty_m2_r;
    row_ty[1] = s1_ty_m1_r;
    // Rows below the current one have not arrived and repeat it.
    for (int i = 2; i < MaxW; i++) begin
      row_ty[i] = smf_pkg::ROW_CUR;
    end

    for (int i = 0; i < MaxW; i++) begin
      for (int j = 0; j < MaxW; j++) begin
        unique case (row_ty[i])
          smf_pkg::ROW_M1: samp[i][j] = rd_m1[s1_bank_r[j]];
          smf_pkg::ROW_M2: samp[i][j] = rd_m2[s1_bank_r[j]];
          default:         samp[i][j] = cur_col[j];
        endcase
      end
    end

    win0 = '0;
    if (s1_mode_r) begin
      for (int i = 0; i < MaxW; i++) begin
        for (int j = 0; j < MaxW; j++) begin
          win0[i*MaxW+j] = samp[i][j];
        end
      end
    end else begin
      for (int i = 0; i < smf_pkg::SMALL_SPAN; i++) begin
        for (int j = 0; j < smf_pkg::SMALL_SPAN; j++) begin
          win0[i*smf_pkg::SMALL_SPAN+j] = samp[i][j];
        end
      end
      for (int n = smf_pkg::SMALL_N; n < smf_pkg::WIN_N; n++) begin
        win0[n] = (n < smf_pkg::PAD_SPLIT) ? smf_pkg::PAD_LOW : smf_pkg::PAD_HIGH;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sorter chain; each slice moves on when the next one is empty or moving.
  // --------------------------------------------------------------------------
  assign sd[0]   = win0;
  assign sv[0]   = s1_v_r;
  assign stag[0] = s1_row_end_r;

  always_comb begin
    sload[Stgs-1] = !sv[Stgs] || !out_stall;
    for (int g = Stgs - 2; g >= 0; g--) begin
      sload[g] = !sv[g+1] || sload[g+1];
    end
  end

  for (genvar g = 0; g < Stgs; g++) begin : g_sort
    smf_sort_stage #(
      .FIRST_PASS (g * smf_pkg::SORT_STAGE_PASSES),
      .NUM_PASSES (smf_pkg::SORT_STAGE_PASSES)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (sload[g]),
      .in_valid  (sv[g]),
      .in_tag    (stag[g]),
      .in_data   (sd[g]),
      .out_valid (sv[g+1]),
      .out_tag   (stag[g+1]),
      .out_data  (sd[g+1])
    );
  end

  assign out_valid        = sv[Stgs];
  assign out_row_end      = stag[Stgs];
  assign out_median_value = sd[Stgs][smf_pkg::WIN_MID];

endmodule
